// ----- sv/pdps_pkg.sv -----
package pdps_pkg;

	localparam int unsigned SAMPLE_WIDTH    = 16;
	localparam int unsigned DIFF_WIDTH      = SAMPLE_WIDTH + 1;
	localparam int unsigned THR_WIDTH       = 16;
	localparam int unsigned CNT_WIDTH       = 13;
	localparam int unsigned CFG_DATA_WIDTH  = 16;
	localparam int unsigned CFG_INDEX_WIDTH = 2;

	localparam logic [CNT_WIDTH-1:0] WEAK_FLOOR          = CNT_WIDTH'(8);
	localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET     = THR_WIDTH'(1024);
	localparam logic [CNT_WIDTH-1:0] WINDOW_LENGTH_RESET = CNT_WIDTH'(64);
	localparam logic [CNT_WIDTH-1:0] RESYNC_COUNT_RESET  = CNT_WIDTH'(32);

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_THRESHOLD     = 2'd0,
		CFG_WINDOW_LENGTH = 2'd1,
		CFG_RESYNC_COUNT  = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [THR_WIDTH-1:0] threshold;
		logic [CNT_WIDTH-1:0] window_length;
		logic [CNT_WIDTH-1:0] resync_count;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_even;
		logic signed [SAMPLE_WIDTH-1:0] sample_odd;
	} in_item_t;

	typedef struct packed {
		logic signed [DIFF_WIDTH-1:0] difference;
		logic                         below_threshold;
		logic                         phase_used;
		logic                         resynced;
	} out_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

endpackage

// ----- sv/pdps_cfg_regs.sv -----
module pdps_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [pdps_pkg::CFG_INDEX_WIDTH-1:0] index,
	input  logic [pdps_pkg::CFG_DATA_WIDTH-1:0]  wr_data,
	output pdps_pkg::cfg_t                       cfg
);

	pdps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= pdps_pkg::THRESHOLD_RESET;
			cfg_q.window_length <= pdps_pkg::WINDOW_LENGTH_RESET;
			cfg_q.resync_count  <= pdps_pkg::RESYNC_COUNT_RESET;
		end else if (wr_en) begin
			case (index)
				pdps_pkg::CFG_THRESHOLD: begin
					cfg_q.threshold <= wr_data[pdps_pkg::THR_WIDTH-1:0];
				end
				pdps_pkg::CFG_WINDOW_LENGTH: begin
					cfg_q.window_length <= wr_data[pdps_pkg::CNT_WIDTH-1:0];
				end
				pdps_pkg::CFG_RESYNC_COUNT: begin
					cfg_q.resync_count <= wr_data[pdps_pkg::CNT_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/pdps_in_stage.sv -----
module pdps_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pdps_pkg::in_item_t in_data,
	input  logic               advance,
	output pdps_pkg::stage_t   stage
);

	logic               valid_s1;
	pdps_pkg::in_item_t data_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = data_s1;

endmodule

// ----- sv/pdps_pair_core.sv -----
module pdps_pair_core (
	input  logic                clk,
	input  logic                arst_n,
	input  pdps_pkg::cfg_t      cfg,
	input  pdps_pkg::stage_t    stage,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_ready,
	output pdps_pkg::out_item_t out_data
);

	localparam int unsigned SW = pdps_pkg::SAMPLE_WIDTH;
	localparam int unsigned DW = pdps_pkg::DIFF_WIDTH;
	localparam int unsigned CW = pdps_pkg::CNT_WIDTH;

	logic signed [SW-1:0] prev_odd_q;
	logic                 phase_q;
	logic [CW-1:0]        weak_count_q;
	logic [CW-1:0]        pair_count_q;
	logic                 out_valid_q;
	pdps_pkg::out_item_t  out_data_s2;

	logic signed [DW-1:0] even_x;
	logic signed [DW-1:0] odd_x;
	logic signed [DW-1:0] prev_x;
	logic signed [DW-1:0] diff;
	logic [DW-1:0]        mag;
	logic                 weak_hit;
	logic [CW-1:0]        weak_next;
	logic [CW-1:0]        pair_next;
	logic                 window_end;
	logic                 flip;

	assign advance = stage.valid && (!out_valid_q || out_ready);

	always_comb begin
		even_x     = {stage.item.sample_even[SW-1], stage.item.sample_even};
		odd_x      = {stage.item.sample_odd[SW-1], stage.item.sample_odd};
		prev_x     = {prev_odd_q[SW-1], prev_odd_q};
		diff       = phase_q ? (prev_x - even_x) : (even_x - odd_x);
		mag        = diff[DW-1] ? DW'(-diff) : DW'(diff);
		weak_hit   = mag < DW'(cfg.threshold);
		weak_next  = weak_count_q + CW'(weak_hit);
		pair_next  = pair_count_q + CW'(1);
		window_end = pair_next >= cfg.window_length;
		flip       = window_end && (weak_next > cfg.resync_count)
			&& (weak_next > pdps_pkg::WEAK_FLOOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_odd_q   <= '0;
			phase_q      <= 1'b0;
			weak_count_q <= '0;
			pair_count_q <= '0;
		end else if (advance) begin
			prev_odd_q <= stage.item.sample_odd;
			phase_q    <= phase_q ^ flip;
			if (window_end) begin
				weak_count_q <= '0;
				pair_count_q <= '0;
			end else begin
				weak_count_q <= weak_next;
				pair_count_q <= pair_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_s2.difference      <= diff;
			out_data_s2.below_threshold <= weak_hit;
			out_data_s2.phase_used      <= phase_q;
			out_data_s2.resynced        <= flip;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_s2;

endmodule

// ----- sv/pair_difference_phase_sync.sv -----
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_data (sample_even, sample_odd)
// out       output     out_valid / out_ready out_data (difference, flags)
// cfg       input      cfg_wr_en             cfg_index, cfg_wr_data
//
// Each pair goes from the input register to the result register; a new pair
// is taken every cycle unless the output stalls. The input register feeds the
// subtract, compare and window counters, which load the result register.
// Reset clears the pairing state, both window counters and the handshake flags;
// the configuration registers return to their default values.
// A stalled output holds the pair in the input register and lowers in_ready.
module pair_difference_phase_sync (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  pdps_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output pdps_pkg::out_item_t                  out_data,
	input  logic                                 cfg_wr_en,
	input  logic [pdps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [pdps_pkg::CFG_DATA_WIDTH-1:0]  cfg_wr_data
);

	pdps_pkg::cfg_t   cfg;
	pdps_pkg::stage_t stage;
	logic             advance;

	pdps_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_wr_en),
		.index   (cfg_index),
		.wr_data (cfg_wr_data),
		.cfg     (cfg)
	);

	pdps_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.stage    (stage)
	);

	pdps_pair_core u_pair_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.stage     (stage),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
